// ===== sv/bleadv_pkg.sv =====
`default_nettype none
package bleadv_pkg;

  // Name capacity as configured, and the depth of one name buffer.
  localparam int NAME_CAP   = 31;
  localparam int NAME_DEPTH = 31;
  localparam int NAME_LIMIT = (NAME_CAP < NAME_DEPTH) ? NAME_CAP : NAME_DEPTH;

  // Bytes at this position and beyond are ignored.
  localparam int MAX_AD_LEN = 31;

  // Field types and the register reset value.
  localparam logic [7:0]  AD_TYPE_UUID16_PART  = 8'h02;
  localparam logic [7:0]  AD_TYPE_UUID16_FULL  = 8'h03;
  localparam logic [7:0]  AD_TYPE_NAME_SHORT   = 8'h08;
  localparam logic [7:0]  AD_TYPE_NAME_FULL    = 8'h09;
  localparam logic [15:0] TARGET_UUID_RESET    = 16'h180D;

  // One name byte written into a buffer bank.
  typedef struct packed {
    logic       en;
    logic       bank;
    logic [4:0] addr;
    logic [7:0] data;
  } name_wr_t;

  // Summary of a finished payload, handed to the result side.
  typedef struct packed {
    logic       valid;
    logic       bank;
    logic [4:0] count;
    logic       service;
  } scan_done_t;

endpackage
`default_nettype wire

// ===== sv/ble_adv_service_and_name_scan.sv =====
`default_nettype none
// Channel   Handshake               Payload
// input     in_valid / in_ready     ad_byte, has_byte, end_of_data
// output    out_valid / out_ready   name_byte, name_index, name_length, has_service, last
// config    target_service_uuid_we  target_service_uuid
//
// One input item is taken per cycle; the field walk finishes in the cycle of its transfer.
// After the end-of-data transfer the name buffer is read once before the first result
// is offered; the rest follow one per cycle while out_ready is high, up to 31,
// read from a name buffer bank while the next payload fills the other.
// The input stalls only on an end-of-data item while an earlier burst is still pending.
// Reset is synchronous and restores the register to 0x180D.
module ble_adv_service_and_name_scan (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        target_service_uuid_we,
  input  wire logic [15:0] target_service_uuid,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  ad_byte,
  input  wire logic        has_byte,
  input  wire logic        end_of_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       name_byte,
  output logic [4:0]       name_index,
  output logic [4:0]       name_length,
  output logic             has_service,
  output logic             last
);

  bleadv_pkg::name_wr_t   wr;
  bleadv_pkg::scan_done_t done;
  logic                   can_start;
  logic                   rd_bank;
  logic [4:0]             rd_addr;
  logic [7:0]             rd_data;
  logic                   take;

  // Input transfer.
  assign in_ready = !end_of_data || can_start;
  assign take     = in_valid && in_ready;

  bleadv_parse u_parse (
    .clk                    (clk),
    .rst                    (rst),
    .target_service_uuid_we (target_service_uuid_we),
    .target_service_uuid    (target_service_uuid),
    .take                   (take),
    .ad_byte                (ad_byte),
    .has_byte               (has_byte),
    .end_of_data            (end_of_data),
    .wr                     (wr),
    .done                   (done)
  );

  bleadv_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_bank (rd_bank),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bleadv_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .done        (done),
    .can_start   (can_start),
    .rd_bank     (rd_bank),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .name_byte   (name_byte),
    .name_index  (name_index),
    .name_length (name_length),
    .has_service (has_service),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== sv/bleadv_store.sv =====
`default_nettype none
module bleadv_store (
  input  wire logic                  clk,
  input  wire bleadv_pkg::name_wr_t  wr,
  input  wire logic                  rd_bank,
  input  wire logic [4:0]            rd_addr,
  output logic [7:0]                 rd_data
);

  // Two banks: one fills while the other is being read out.
  logic [7:0] mem [2][bleadv_pkg::NAME_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.bank][wr.addr] <= wr.data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_bank][rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/bleadv_parse.sv =====
`default_nettype none
module bleadv_parse (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    target_service_uuid_we,
  input  wire logic [15:0]             target_service_uuid,
  input  wire logic                    take,
  input  wire logic [7:0]              ad_byte,
  input  wire logic                    has_byte,
  input  wire logic                    end_of_data,
  output bleadv_pkg::name_wr_t         wr,
  output bleadv_pkg::scan_done_t       done
);

  logic [15:0] target;
  logic [7:0]  byte_position, byte_position_next;
  logic [7:0]  field_start, field_start_next;
  logic [7:0]  field_length, field_length_next;
  logic [7:0]  field_kind, field_kind_next;
  logic [7:0]  uuid_low_byte, uuid_low_byte_next;
  logic        walk_stopped, walk_stopped_next;
  logic        seen, seen_next;
  logic        service_found, service_found_next;
  logic        name_taken, name_taken_next;
  logic [4:0]  name_count, name_count_next;
  logic        bank;

  logic        active;
  logic [7:0]  off;
  logic [7:0]  name_idx;
  logic [7:0]  len_m1;
  logic        is_list;
  logic        is_name;

  // Register written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= bleadv_pkg::TARGET_UUID_RESET;
    end else if (target_service_uuid_we) begin
      target <= target_service_uuid;
    end
  end

  // Walk of the length-type-value fields for one byte.
  always_comb begin
    byte_position_next = byte_position;
    field_start_next   = field_start;
    field_length_next  = field_length;
    field_kind_next    = field_kind;
    uuid_low_byte_next = uuid_low_byte;
    walk_stopped_next  = walk_stopped;
    seen_next          = seen;
    service_found_next = service_found;
    name_taken_next    = name_taken;
    name_count_next    = name_count;
    wr                 = '0;
    wr.bank            = bank;
    wr.data            = ad_byte;

    active   = has_byte && !walk_stopped
               && (byte_position < 8'(bleadv_pkg::MAX_AD_LEN));
    off      = byte_position - field_start;
    name_idx = off - 8'd2;
    len_m1   = field_length - 8'd1;
    wr.addr  = name_idx[4:0];
    is_list  = 1'b0;
    is_name  = 1'b0;

    if (active) begin
      byte_position_next = byte_position + 8'd1;
      if (off == 8'd0) begin
        // Length byte: zero ends the walk.
        if (ad_byte == 8'd0) begin
          walk_stopped_next = 1'b1;
        end else begin
          field_length_next = ad_byte;
          seen_next         = 1'b0;
        end
      end else begin
        if (off == 8'd1) begin
          field_kind_next = ad_byte;
        end
        is_list = (field_kind_next == bleadv_pkg::AD_TYPE_UUID16_PART)
                  || (field_kind_next == bleadv_pkg::AD_TYPE_UUID16_FULL);
        is_name = (field_kind_next == bleadv_pkg::AD_TYPE_NAME_SHORT)
                  || (field_kind_next == bleadv_pkg::AD_TYPE_NAME_FULL);

        // Value bytes: UUID pairs and name bytes.
        if (off >= 8'd2) begin
          if (is_list) begin
            if (!off[0]) begin
              uuid_low_byte_next = ad_byte;
            end else if ({ad_byte, uuid_low_byte} == target) begin
              seen_next = 1'b1;
            end
          end
          if (is_name && !name_taken && (name_idx < 8'(bleadv_pkg::NAME_LIMIT))) begin
            wr.en = 1'b1;
          end
        end

        // Last byte of the field: commit what it held.
        if (off == field_length) begin
          if (is_list && seen_next) begin
            service_found_next = 1'b1;
          end
          if (is_name && !name_taken && (field_length >= 8'd2)) begin
            name_taken_next = 1'b1;
            if (len_m1 < 8'(bleadv_pkg::NAME_LIMIT)) begin
              name_count_next = len_m1[4:0];
            end else begin
              name_count_next = 5'(bleadv_pkg::NAME_LIMIT);
            end
          end
          field_start_next = byte_position + 8'd1;
        end
      end
    end

    wr.en        = wr.en && take;
    done.valid   = take && end_of_data;
    done.bank    = bank;
    done.count   = name_count_next;
    done.service = service_found_next;
  end

  // Per-payload state; cleared after the end of a payload.
  always_ff @(posedge clk) begin
    if (rst || done.valid) begin
      byte_position <= '0;
      field_start   <= '0;
      field_length  <= '0;
      field_kind    <= '0;
      uuid_low_byte <= '0;
      walk_stopped  <= 1'b0;
      seen          <= 1'b0;
      service_found <= 1'b0;
      name_taken    <= 1'b0;
      name_count    <= '0;
    end else if (take) begin
      byte_position <= byte_position_next;
      field_start   <= field_start_next;
      field_length  <= field_length_next;
      field_kind    <= field_kind_next;
      uuid_low_byte <= uuid_low_byte_next;
      walk_stopped  <= walk_stopped_next;
      seen          <= seen_next;
      service_found <= service_found_next;
      name_taken    <= name_taken_next;
      name_count    <= name_count_next;
    end
  end

  // The next payload fills the other bank.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (done.valid) begin
      bank <= ~bank;
    end
  end

endmodule
`default_nettype wire

// ===== sv/bleadv_emit.sv =====
`default_nettype none
module bleadv_emit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire bleadv_pkg::scan_done_t  done,
  output logic                         can_start,
  output logic                         rd_bank,
  output logic [4:0]                   rd_addr,
  input  wire logic [7:0]              rd_data,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [7:0]                   name_byte,
  output logic [4:0]                   name_index,
  output logic [4:0]                   name_length,
  output logic                         has_service,
  output logic                         last
);

  logic       busy;
  logic       primed;
  logic [4:0] idx;
  logic [4:0] cnt;
  logic       svc;
  logic       bank;
  logic       step;
  logic       finish;

  // Result fields follow the burst registers; the name byte was read in the cycle before.
  assign last        = (cnt == 5'd0) || (idx == cnt - 5'd1);
  assign out_valid   = busy && primed;
  assign name_byte   = (cnt == 5'd0) ? 8'd0 : rd_data;
  assign name_index  = idx;
  assign name_length = cnt;
  assign has_service = svc;

  // Transfers that move to the next byte or end the burst.
  assign step   = out_valid && out_ready && !last;
  assign finish = out_valid && out_ready && last;

  // The buffer is read ahead: the next index while the current result transfers.
  assign rd_bank = bank;
  assign rd_addr = step ? (idx + 5'd1) : idx;

  // A new burst may load once the current one transfers its last result.
  assign can_start = !busy || finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (done.valid) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  // The first byte of a burst is read from the buffer before it is offered.
  always_ff @(posedge clk) begin
    if (rst || done.valid) begin
      primed <= 1'b0;
    end else begin
      primed <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (done.valid) begin
      idx  <= '0;
      cnt  <= done.count;
      svc  <= done.service;
      bank <= done.bank;
    end else if (step) begin
      idx <= idx + 5'd1;
    end
  end

endmodule
`default_nettype wire

// ===== tb/sv/ble_adv_service_and_name_scan_tb.sv =====
`timescale 1ns / 100ps
module ble_adv_service_and_name_scan_tb;

  localparam int CYCLE_LIMIT = 200000;

  // One input transfer as the sender offers it.
  typedef struct packed {
    logic [7:0] b;
    logic       hb;
    logic       eod;
  } ad_item_t;

  // One name result as the block should produce it.
  typedef struct packed {
    logic [7:0] nb;
    logic [4:0] idx;
    logic [4:0] len;
    logic       svc;
    logic       last;
  } name_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_uuid = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  ad_byte = '0;
  logic        has_byte = 1'b0;
  logic        end_of_data = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  name_byte;
  logic [4:0]  name_index;
  logic [4:0]  name_length;
  logic        has_service;
  logic        last;

  ad_item_t     payload_items[$];
  name_result_t expected_names[$];
  name_result_t seen_name;
  name_result_t want_name;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_request = 0;
  int unsigned  hold_left = 0;

  // Scanner state kept by the testbench.
  logic [15:0] scan_target;
  int unsigned scan_pos;
  int unsigned scan_fstart;
  int unsigned scan_flen;
  logic [7:0]  scan_kind;
  logic [7:0]  scan_uuid_lo;
  bit          scan_stopped;
  bit          scan_svc_field;
  bit          scan_svc_found;
  bit          scan_name_taken;
  int unsigned scan_name_cnt;
  logic [7:0]  scan_name_buf [bleadv_pkg::NAME_DEPTH];

  ble_adv_service_and_name_scan i_dut (
    .clk                    (clk),
    .rst                    (rst),
    .target_service_uuid_we (cfg_we),
    .target_service_uuid    (cfg_uuid),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .ad_byte                (ad_byte),
    .has_byte               (has_byte),
    .end_of_data            (end_of_data),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .name_byte              (name_byte),
    .name_index             (name_index),
    .name_length            (name_length),
    .has_service            (has_service),
    .last                   (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Per-payload state is cleared after every end of data.
  function automatic void clear_scan();
    scan_pos        = 0;
    scan_fstart     = 0;
    scan_flen       = 0;
    scan_kind       = '0;
    scan_uuid_lo    = '0;
    scan_stopped    = 1'b0;
    scan_svc_field  = 1'b0;
    scan_svc_found  = 1'b0;
    scan_name_taken = 1'b0;
    scan_name_cnt   = 0;
  endfunction

  // Walks one valid payload byte through the length-type-value fields.
  function automatic void walk_byte(logic [7:0] b);
    int unsigned p;
    int unsigned off;
    int unsigned n;
    bit          is_list;
    bit          is_name;
    p = scan_pos;
    if (scan_stopped || p >= bleadv_pkg::MAX_AD_LEN) return;
    scan_pos = (p + 1) & 8'hFF;

    // A length byte opens a field, and a zero one ends the walk.
    if (p == scan_fstart) begin
      if (b == 8'h00) begin
        scan_stopped = 1'b1;
      end else begin
        scan_flen      = b;
        scan_svc_field = 1'b0;
      end
      return;
    end

    off = (p - scan_fstart) & 8'hFF;
    if (off == 1) scan_kind = b;
    is_list = (scan_kind == bleadv_pkg::AD_TYPE_UUID16_PART)
              || (scan_kind == bleadv_pkg::AD_TYPE_UUID16_FULL);
    is_name = (scan_kind == bleadv_pkg::AD_TYPE_NAME_SHORT)
              || (scan_kind == bleadv_pkg::AD_TYPE_NAME_FULL);

    // Data bytes: UUID pairs are little-endian, name bytes go to the buffer.
    if (off >= 2) begin
      if (is_list) begin
        if ((off & 1) == 0) begin
          scan_uuid_lo = b;
        end else if ({b, scan_uuid_lo} == scan_target) begin
          scan_svc_field = 1'b1;
        end
      end
      if (is_name && !scan_name_taken && (off - 2) < bleadv_pkg::NAME_LIMIT) begin
        scan_name_buf[off - 2] = b;
      end
    end

    // Only a field whose last byte arrived counts.
    if (off == scan_flen) begin
      if (is_list && scan_svc_field) scan_svc_found = 1'b1;
      if (is_name && !scan_name_taken && scan_flen >= 2) begin
        n               = scan_flen - 1;
        scan_name_taken = 1'b1;
        scan_name_cnt   = (n < bleadv_pkg::NAME_LIMIT) ? n : bleadv_pkg::NAME_LIMIT;
      end
      scan_fstart = (p + 1) & 8'hFF;
    end
  endfunction

  // Updates the scanner for one accepted item and queues the results it causes.
  function automatic void scan_ad_item(ad_item_t it);
    name_result_t r;
    if (it.hb) walk_byte(it.b);
    if (!it.eod) return;
    if (scan_name_cnt == 0) begin
      r      = '0;
      r.svc  = scan_svc_found;
      r.last = 1'b1;
      expected_names.push_back(r);
    end else begin
      for (int unsigned i = 0; i < scan_name_cnt; i++) begin
        r.nb   = scan_name_buf[i];
        r.idx  = i[4:0];
        r.len  = scan_name_cnt[4:0];
        r.svc  = scan_svc_found;
        r.last = (i + 1 == scan_name_cnt);
        expected_names.push_back(r);
      end
    end
    clear_scan();
  endfunction

  function automatic void add_byte(logic [7:0] b, bit hb = 1'b1, bit eod = 1'b0);
    ad_item_t it;
    it.b   = b;
    it.hb  = hb;
    it.eod = eod;
    payload_items.push_back(it);
  endfunction

  // Valid byte of a random payload, now and then preceded by an invalid one.
  function automatic void add_data(logic [7:0] b);
    if ($urandom_range(99) < 4) add_byte(8'($urandom_range(255)), 1'b0);
    add_byte(b);
  endfunction

  // Builds one random payload: mostly well-formed fields, some noise,
  // cut-off fields, overlong payloads and early stops.
  function automatic void build_payload();
    int unsigned start;
    int unsigned budget;
    int unsigned k;
    int unsigned n;
    bit          odd;
    logic [15:0] uuid;
    start = payload_items.size();
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, 40);
      repeat (n) add_byte(8'($urandom_range(255)), $urandom_range(99) < 85);
    end else begin
      budget = ($urandom_range(99) < 10) ? $urandom_range(32, 45) : $urandom_range(2, 31);
      while (payload_items.size() - start < budget) begin
        k = $urandom_range(99);
        if (k < 40) begin
          n   = $urandom_range(0, 4);
          odd = ($urandom_range(3) == 0);
          add_data(8'(1 + 2 * n + odd));
          add_data($urandom_range(1) ? bleadv_pkg::AD_TYPE_UUID16_FULL
                                     : bleadv_pkg::AD_TYPE_UUID16_PART);
          repeat (n) begin
            uuid = $urandom_range(1) ? scan_target : 16'($urandom_range(65535));
            add_data(uuid[7:0]);
            add_data(uuid[15:8]);
          end
          if (odd) add_data(8'($urandom_range(255)));
        end else if (k < 75) begin
          n = ($urandom_range(9) == 0) ? $urandom_range(7, 29) : $urandom_range(0, 6);
          add_data(8'(n + 1));
          add_data($urandom_range(1) ? bleadv_pkg::AD_TYPE_NAME_FULL
                                     : bleadv_pkg::AD_TYPE_NAME_SHORT);
          repeat (n) add_data(8'($urandom_range(255)));
        end else if (k < 95) begin
          n = $urandom_range(0, 5);
          add_data(8'(n + 1));
          add_data(8'($urandom_range(255)));
          repeat (n) add_data(8'($urandom_range(255)));
        end else begin
          add_data(8'h00);
          repeat ($urandom_range(0, 3)) add_data(8'($urandom_range(255)));
        end
      end
      // Dropping the tail leaves the last field cut off.
      if ($urandom_range(99) < 15) begin
        n = $urandom_range(1, 3);
        while (n != 0 && payload_items.size() > start + 1) begin
          void'(payload_items.pop_back());
          n--;
        end
      end
    end
    if ($urandom_range(9) == 0) begin
      add_byte(8'($urandom_range(255)), 1'b0, 1'b1);
    end else begin
      payload_items[payload_items.size() - 1].eod = 1'b1;
    end
  endfunction

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // Sends the queued items, with random gaps, and predicts each transfer.
  task automatic send_items();
    int unsigned gap;
    foreach (payload_items[i]) begin
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clk);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid    <= 1'b1;
      ad_byte     <= payload_items[i].b;
      has_byte    <= payload_items[i].hb;
      end_of_data <= payload_items[i].eod;
      do @(posedge clk); while (!in_ready);
      scan_ad_item(payload_items[i]);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    payload_items.delete();
  endtask

  task automatic wait_drained();
    while (expected_names.size() != 0) @(posedge clk);
  endtask

  // The register is written only with the block idle.
  task automatic set_target(logic [15:0] uuid);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_uuid <= uuid;
    @(negedge clk);
    cfg_we <= 1'b0;
    scan_target = uuid;
  endtask

  // Two empty payloads, each ended by an item without a valid byte.
  task automatic test_empty_payload();
    add_byte(8'h00, 1'b0, 1'b1);
    add_byte(8'hFF, 1'b0, 1'b1);
    send_items();
  endtask

  // A matching full UUID list, an empty name field that is skipped, an invalid
  // byte, a short name that is taken, and a zero length byte that ends the walk.
  task automatic test_lists_and_names();
    add_byte(8'h03);
    add_byte(bleadv_pkg::AD_TYPE_UUID16_FULL);
    add_byte(scan_target[7:0]);
    add_byte(scan_target[15:8]);
    add_byte(8'h01);
    add_byte(bleadv_pkg::AD_TYPE_NAME_FULL);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h04);
    add_byte(bleadv_pkg::AD_TYPE_NAME_SHORT);
    add_byte(8'h41);
    add_byte(8'h7E);
    add_byte(8'hFF);
    add_byte(8'h00, 1'b1, 1'b1);
    send_items();
  endtask

  // A one-byte name, then a partial UUID list that holds the target but is cut off by the end.
  task automatic test_cut_off_field();
    add_byte(8'h02);
    add_byte(bleadv_pkg::AD_TYPE_NAME_FULL);
    add_byte(8'h5A);
    add_byte(8'hFF);
    add_byte(bleadv_pkg::AD_TYPE_UUID16_PART);
    add_byte(scan_target[7:0]);
    add_byte(scan_target[15:8], 1'b1, 1'b1);
    send_items();
  endtask

  // The receiver holds off for a long stretch while named payloads keep coming.
  task automatic test_output_stall();
    repeat (6) begin
      add_byte(8'h07);
      add_byte(bleadv_pkg::AD_TYPE_NAME_FULL);
      repeat (6) add_byte(8'($urandom_range(255)));
      payload_items[payload_items.size() - 1].eod = 1'b1;
    end
    hold_request = 300;
    send_items();
  endtask

  task automatic test_random_payloads(int unsigned n_items);
    while (payload_items.size() < n_items) build_payload();
    send_items();
  endtask

  // Receiver: random stalls, or a held-off stretch when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result transfer is checked against the oldest expected name result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_name = {name_byte, name_index, name_length, has_service, last};
      if (expected_names.size() == 0) begin
        note_mismatch($sformatf("unexpected result: byte %02h idx %0d len %0d svc %b last %b",
                                name_byte, name_index, name_length, has_service, last));
      end else begin
        want_name = expected_names.pop_front();
        if (seen_name.nb != want_name.nb || seen_name.idx != want_name.idx ||
            seen_name.len != want_name.len || seen_name.svc != want_name.svc ||
            seen_name.last != want_name.last) begin
          note_mismatch($sformatf(
            "result mismatch: want %02h idx %0d len %0d svc %b last %b, got %02h %0d %0d %b %b",
            want_name.nb, want_name.idx, want_name.len, want_name.svc, want_name.last,
            seen_name.nb, seen_name.idx, seen_name.len, seen_name.svc, seen_name.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    scan_target = bleadv_pkg::TARGET_UUID_RESET;
    clear_scan();
    foreach (scan_name_buf[i]) scan_name_buf[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks run with the reset UUID and the first idle mix.
    send_idle_pct = 25;
    recv_idle_pct = 77;
    test_empty_payload();
    test_lists_and_names();
    test_cut_off_field();

    set_target(16'h0000);
    test_random_payloads(90);
    test_output_stall();

    set_target(16'hFFFF);
    send_idle_pct = 77;
    recv_idle_pct = 25;
    test_random_payloads(90);

    set_target(16'($urandom_range(65535)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_payloads(90);

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_names.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
